// ===== rtl/tcw_pkg.sv =====
// shared types and constants for the text console writer
package tcw_pkg;

  localparam int CELL_W      = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_ZERO    = 8'd0;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        char_code;
    logic [7:0]        attribute;
    logic [CELL_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cursor_cell;
    logic [7:0]        read_char;
    logic [7:0]        read_attribute;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        code;
    logic [7:0]        attr;
    logic [CELL_W-1:0] cell_idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_PUT_LAST,
    ST_FILL
  } back_state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// top level of the text console writer
//
// character-cell console of COLUMNS x ROWS cells with a write cursor. each
// input beat carries one operation (put character, clear screen, read cell)
// and yields exactly one result beat with the cursor position after the
// operation and, for a read, the cell's character and attribute bytes.
// both sides are queues: push/full on the input, empty/pop on the results.
// after reset the screen memory is swept to zero, one cell a cycle; full
// stays high during that sweep.
// back end, from the cycle a command leaves the command queue: a character
// write or a newline that does not scroll, an out-of-range read or an
// unknown operation yields its result in that cycle; a read yields its
// result from a registered memory read. a scroll picks up the command, then
// walks the screen memory: row copy, then blanking of the last row, plus,
// for a put, the write of the character that caused it. a clear fills
// every cell with a space and the command's attribute.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  // command queue between front and back
  logic      cmd_push;
  cmd_t      cmd_in;
  cmd_t      cmd_out;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;

  // result path
  logic      res_push;
  out_item_t res;
  logic      res_full;

  logic      init_busy;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .init_busy (init_busy),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .init_busy (init_busy)
  );

  // result queue: back end only starts a command while a slot is free
  tcw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (out_item),
    .full    (res_full),
    .empty   (empty)
  );

endmodule

// ===== rtl/tcw_fifo.sv =====
// small register queue used between the stages and at the result side
module tcw_fifo import tcw_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/tcw_front.sv =====
// front end: takes input beats and turns them into commands
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     init_busy,
  input  logic     cmd_full,
  output logic     cmd_push,
  output cmd_t     cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  logic in_range;

  assign full     = cmd_full || init_busy;
  assign cmd_push = push && !full;
  assign in_range = (32'(in_item.cell_index) < 32'(CELLS));

  always_comb begin
    cmd.code     = in_item.char_code;
    cmd.attr     = in_item.attribute;
    cmd.cell_idx = in_item.cell_index;
    case (in_item.operation)
      OP_PUT:   cmd.kind = (in_item.char_code == CODE_NEWLINE) ? CMD_NEWLINE : CMD_PUT;
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      OP_READ:  cmd.kind = in_range ? CMD_READ : CMD_NONE;
      default:  cmd.kind = CMD_NONE;
    endcase
  end

endmodule

// ===== rtl/tcw_back.sv =====
// back end: screen memory, cursor and the scroll / clear sequencer
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res,
  output logic      init_busy
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int NW    = $clog2(CELLS + COLUMNS + 1);

  logic [7:0] chars [CELLS];
  logic [7:0] attrs [CELLS];

  back_state_t   state, state_next;
  logic [NW-1:0] cnt, cnt_next;
  logic          copy_v, copy_v_next;
  logic [AW-1:0] dst, dst_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [NW-1:0] next_line, next_line_next;
  cmd_t          cur, cur_next;
  logic [7:0]    rd_char;
  logic [7:0]    rd_attr;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          we_c;
  logic          we_a;
  logic [AW-1:0] waddr;
  logic [7:0]    wchar;
  logic [7:0]    wattr;
  logic          read_out;

  assign init_busy = (state == ST_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      copy_v    <= 1'b0;
      cursor    <= '0;
      next_line <= NW'(COLUMNS);
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      copy_v    <= copy_v_next;
      cursor    <= cursor_next;
      next_line <= next_line_next;
    end
  end

  always_ff @(posedge clk) begin
    dst <= dst_next;
    cur <= cur_next;
  end

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_c) begin
      chars[waddr] <= wchar;
    end
    if (we_a) begin
      attrs[waddr] <= wattr;
    end
    if (mem_re) begin
      rd_char <= chars[mem_raddr];
      rd_attr <= attrs[mem_raddr];
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    copy_v_next    = 1'b0;
    dst_next       = dst;
    cursor_next    = cursor;
    next_line_next = next_line;
    cur_next       = cur;
    mem_re         = 1'b0;
    mem_raddr      = cnt[AW-1:0];
    we_c           = 1'b0;
    we_a           = 1'b0;
    waddr          = cnt[AW-1:0];
    wchar          = CODE_SPACE;
    wattr          = cur.attr;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    read_out       = 1'b0;

    case (state)
      ST_INIT: begin
        we_c     = 1'b1;
        we_a     = 1'b1;
        wchar    = CODE_ZERO;
        wattr    = CODE_ZERO;
        cnt_next = cnt + 1'b1;
        if (cnt == NW'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          case (cmd.kind)
            CMD_PUT: begin
              if (cursor == CW'(CELLS)) begin
                cnt_next   = NW'(COLUMNS);
                state_next = ST_SCROLL;
              end else begin
                we_c        = 1'b1;
                waddr       = cursor[AW-1:0];
                wchar       = cmd.code;
                cursor_next = cursor + 1'b1;
                if (NW'(cursor) + 1'b1 == next_line) begin
                  next_line_next = next_line + NW'(COLUMNS);
                end
                res_push = 1'b1;
              end
            end
            CMD_NEWLINE: begin
              if (next_line >= NW'(CELLS)) begin
                cnt_next   = NW'(COLUMNS);
                state_next = ST_SCROLL;
              end else begin
                cursor_next    = CW'(next_line);
                next_line_next = next_line + NW'(COLUMNS);
                res_push       = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cnt_next   = '0;
              state_next = ST_FILL;
            end
            CMD_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(cmd.cell_idx);
              state_next = ST_READ_WAIT;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end

      ST_READ_WAIT: begin
        read_out   = 1'b1;
        res_push   = 1'b1;
        state_next = ST_IDLE;
      end

      ST_SCROLL: begin
        // read a row ahead, write the registered data one row up
        if (cnt < NW'(CELLS)) begin
          mem_re      = 1'b1;
          mem_raddr   = cnt[AW-1:0];
          cnt_next    = cnt + 1'b1;
          copy_v_next = 1'b1;
          dst_next    = AW'(cnt - NW'(COLUMNS));
        end
        if (copy_v) begin
          we_c  = 1'b1;
          we_a  = 1'b1;
          waddr = dst;
          wchar = rd_char;
          wattr = rd_attr;
          if (dst == AW'(LAST - 1)) begin
            cnt_next   = NW'(LAST);
            state_next = ST_BLANK;
          end
        end
      end

      ST_BLANK: begin
        we_c     = 1'b1;
        wchar    = CODE_SPACE;
        cnt_next = cnt + 1'b1;
        if (cnt == NW'(CELLS - 1)) begin
          if (cur.kind == CMD_PUT) begin
            state_next = ST_PUT_LAST;
          end else begin
            cursor_next    = CW'(LAST);
            next_line_next = NW'(CELLS);
            res_push       = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end

      ST_PUT_LAST: begin
        we_c           = 1'b1;
        waddr          = AW'(LAST);
        wchar          = cur.code;
        cursor_next    = CW'(LAST + 1);
        next_line_next = NW'(CELLS);
        res_push       = 1'b1;
        state_next     = ST_IDLE;
      end

      ST_FILL: begin
        we_c     = 1'b1;
        we_a     = 1'b1;
        wchar    = CODE_SPACE;
        wattr    = cur.attr;
        cnt_next = cnt + 1'b1;
        if (cnt == NW'(CELLS - 1)) begin
          cnt_next       = '0;
          cursor_next    = '0;
          next_line_next = NW'(COLUMNS);
          res_push       = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.cursor_cell    = CELL_W'(cursor_next);
    res.read_char      = read_out ? rd_char : CODE_ZERO;
    res.read_attribute = read_out ? rd_attr : CODE_ZERO;
  end

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level checks for the text console writer, bound to the top level
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  in_item,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  localparam int CELLS = COLUMNS * ROWS;

  // memory sweep after reset holds off input
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input not held off after reset");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (CELLS > 2047 || 32'(out_item.cursor_cell) <= 32'(CELLS)))
    else $error("cursor beyond end of screen");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .in_item  (in_item),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
